>>> src/stok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, token codes and character tables of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  // Default sizing
  localparam longint unsigned MAX_SOURCE_LENGTH_DEF = 64'd65536;
  localparam int              KEYWORD_CHARS_DEF     = 6;

  // Output queue depth (two records may arrive with one item)
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [5:0] kind_t;
  typedef logic [1:0] status_t;

  // Operators
  localparam kind_t KIND_ADD_WRAP = 6'd0;   // +%
  localparam kind_t KIND_SUB_WRAP = 6'd1;   // -%
  localparam kind_t KIND_MUL_WRAP = 6'd2;   // *%
  localparam kind_t KIND_DIV_WRAP = 6'd3;   // /%
  localparam kind_t KIND_INC      = 6'd4;   // ++
  localparam kind_t KIND_DEC      = 6'd5;   // --
  localparam kind_t KIND_PLUS     = 6'd6;
  localparam kind_t KIND_MINUS    = 6'd7;
  localparam kind_t KIND_STAR     = 6'd8;
  localparam kind_t KIND_SLASH    = 6'd9;
  localparam kind_t KIND_PERCENT  = 6'd10;
  localparam kind_t KIND_SCOPE    = 6'd11;  // ::
  localparam kind_t KIND_COLON    = 6'd12;
  localparam kind_t KIND_SEMI     = 6'd13;
  localparam kind_t KIND_AT       = 6'd14;
  localparam kind_t KIND_LPAREN   = 6'd15;
  localparam kind_t KIND_RPAREN   = 6'd16;
  localparam kind_t KIND_LBRACK   = 6'd17;
  localparam kind_t KIND_RBRACK   = 6'd18;
  localparam kind_t KIND_LBRACE   = 6'd19;
  localparam kind_t KIND_RBRACE   = 6'd20;
  localparam kind_t KIND_LT       = 6'd21;
  localparam kind_t KIND_GT       = 6'd22;
  localparam kind_t KIND_COMMA    = 6'd23;
  localparam kind_t KIND_ASSIGN   = 6'd24;
  // Words
  localparam kind_t KIND_KW_IF    = 6'd25;  // first of nine keywords
  localparam kind_t KIND_BOOLEAN  = 6'd34;
  localparam kind_t KIND_IDENT    = 6'd35;
  localparam kind_t KIND_STRING   = 6'd36;
  localparam kind_t KIND_NUMBER   = 6'd37;
  // Kind field of an error record
  localparam kind_t KIND_NONE     = 6'd0;

  localparam status_t ST_TOKEN    = 2'd0;
  localparam status_t ST_BAD_CHAR = 2'd1;
  localparam status_t ST_UNTERM   = 2'd2;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;

  // Keyword and boolean words, packed first character highest
  localparam int NUM_WORDS    = 11;
  localparam int NUM_KEYWORDS = 9;
  localparam logic [63:0] WORD_TEXT [NUM_WORDS] = '{
    64'h6966,            // if
    64'h666F72,          // for
    64'h7768696C65,      // while
    64'h766172,          // var
    64'h6D7574,          // mut
    64'h666E,            // fn
    64'h737472756374,    // struct
    64'h656E756D,        // enum
    64'h72657475726E,    // return
    64'h74727565,        // true
    64'h66616C7365       // false
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd2, 4'd3, 4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd4, 4'd6, 4'd4, 4'd5
  };

  // One result record
  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] len;
    status_t     status;
    logic        last;
  } rec_t;

  // Records produced by one item, towards the output queue
  typedef struct packed {
    logic [1:0] n;
    rec_t       rec1;
    rec_t       rec0;
  } push_t;

  // Operator lookup result
  typedef struct packed {
    logic  hit;
    kind_t kind;
  } op_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Operators that may still grow into a two-character operator
  function automatic op_t single_kind(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      CH_PLUS:  r.kind = KIND_PLUS;
      CH_MINUS: r.kind = KIND_MINUS;
      CH_STAR:  r.kind = KIND_STAR;
      CH_SLASH: r.kind = KIND_SLASH;
      CH_COLON: r.kind = KIND_COLON;
      default: begin
        r.hit  = 1'b0;
        r.kind = KIND_NONE;
      end
    endcase
    return r;
  endfunction

  // Operators complete after one character
  function automatic op_t immediate_kind(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      CH_PCT:  r.kind = KIND_PERCENT;
      8'h3B:   r.kind = KIND_SEMI;
      8'h40:   r.kind = KIND_AT;
      8'h28:   r.kind = KIND_LPAREN;
      8'h29:   r.kind = KIND_RPAREN;
      8'h5B:   r.kind = KIND_LBRACK;
      8'h5D:   r.kind = KIND_RBRACK;
      8'h7B:   r.kind = KIND_LBRACE;
      8'h7D:   r.kind = KIND_RBRACE;
      8'h3C:   r.kind = KIND_LT;
      8'h3E:   r.kind = KIND_GT;
      8'h2C:   r.kind = KIND_COMMA;
      8'h3D:   r.kind = KIND_ASSIGN;
      default: begin
        r.hit  = 1'b0;
        r.kind = KIND_NONE;
      end
    endcase
    return r;
  endfunction

  // Two-character operators
  function automatic op_t pair_kind(input logic [7:0] first, input logic [7:0] second);
    op_t r;
    r.hit  = 1'b1;
    r.kind = KIND_NONE;
    if (second == CH_PCT && first == CH_PLUS)        r.kind = KIND_ADD_WRAP;
    else if (second == CH_PCT && first == CH_MINUS)  r.kind = KIND_SUB_WRAP;
    else if (second == CH_PCT && first == CH_STAR)   r.kind = KIND_MUL_WRAP;
    else if (second == CH_PCT && first == CH_SLASH)  r.kind = KIND_DIV_WRAP;
    else if (first == CH_PLUS && second == CH_PLUS)  r.kind = KIND_INC;
    else if (first == CH_MINUS && second == CH_MINUS) r.kind = KIND_DEC;
    else if (first == CH_COLON && second == CH_COLON) r.kind = KIND_SCOPE;
    else r.hit = 1'b0;
    return r;
  endfunction

  // Keyword / boolean match on the packed head of an identifier
  function automatic kind_t word_kind(input logic [63:0] text, input logic [15:0] len);
    kind_t k;
    k = KIND_IDENT;
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (len == 16'(WORD_LEN[i]) && text == WORD_TEXT[i]) begin
        k = (i < NUM_KEYWORDS) ? KIND_KW_IF + 6'(i) : KIND_BOOLEAN;
      end
    end
    return k;
  endfunction

endpackage

>>> src/stok_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_lexer
// Lexer state and per-character decode; yields up to two records per item.
// ----------------------------------------------------------------------------
module stok_lexer #(
  parameter longint unsigned MAX_SOURCE_LENGTH = stok_pkg::MAX_SOURCE_LENGTH_DEF,
  parameter int              KEYWORD_CHARS     = stok_pkg::KEYWORD_CHARS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      char_i,
  input  logic            eos_i,
  output stok_pkg::push_t push_o
);
  import stok_pkg::*;

  localparam int POS_W = $clog2(MAX_SOURCE_LENGTH);
  localparam int KW_W  = 8 * KEYWORD_CHARS;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_OP     = 6'b000010,
    MODE_IDENT  = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_NUMBER = 6'b010000,
    MODE_HALT   = 6'b100000
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       start_q, start_d;
  logic [7:0]        pend_q, pend_d;
  logic [7:0]        quote_q, quote_d;
  logic [KW_W-1:0]   kwbuf_q, kwbuf_d;
  logic [15:0]       len_q, len_d;

  logic [63:0]       pos_wide;
  logic [15:0]       pos16;
  logic [POS_W:0]    pos_inc;
  logic              pos_wrap;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic rec_t mk_rec(input kind_t k, input logic [15:0] s,
                                  input logic [15:0] l, input status_t st);
    rec_t r;
    r.kind   = k;
    r.start  = s;
    r.len    = l;
    r.status = st;
    r.last   = 1'b0;
    return r;
  endfunction

  // Identifiers longer than the keyword buffer are never keywords
  function automatic kind_t ident_kind(input logic [KW_W-1:0] b, input logic [15:0] l);
    return (l > 16'(KEYWORD_CHARS)) ? KIND_IDENT : word_kind(64'(b), l);
  endfunction

  // Position of this character, low 16 bits, and its successor
  assign pos_wide = 64'(pos_q);
  assign pos16    = pos_wide[15:0];
  assign pos_inc  = {1'b0, pos_q} + (POS_W+1)'(1);
  assign pos_wrap = 64'(pos_inc) >= MAX_SOURCE_LENGTH;

  // Decode: continue the open token, start a new one, then flush at end
  always_comb begin
    logic       consumed;
    logic [1:0] n;
    rec_t       recs [2];
    op_t        pk;
    op_t        sk;
    op_t        ik;
    op_t        pend_op;
    op_t        flush_op;

    mode_d   = mode_q;
    start_d  = start_q;
    pend_d   = pend_q;
    quote_d  = quote_q;
    kwbuf_d  = kwbuf_q;
    len_d    = len_q;
    consumed = 1'b0;
    n        = 2'd0;
    recs[0]  = '0;
    recs[1]  = '0;
    pk       = pair_kind(pend_q, char_i);
    sk       = single_kind(char_i);
    ik       = immediate_kind(char_i);
    pend_op  = single_kind(pend_q);

    // open token
    case (mode_q)
      MODE_OP: begin
        if (pk.hit) begin
          recs[n[0]] = mk_rec(pk.kind, start_q, 16'd2, ST_TOKEN);
          n = n + 2'd1;
          consumed = 1'b1;
        end else begin
          recs[n[0]] = mk_rec(pend_op.kind, start_q, 16'd1, ST_TOKEN);
          n = n + 2'd1;
        end
        mode_d = MODE_IDLE;
      end
      MODE_IDENT: begin
        if (is_alpha(char_i) || is_digit(char_i) || char_i == CH_UNDER) begin
          if (len_q < 16'(KEYWORD_CHARS)) kwbuf_d = {kwbuf_q[KW_W-9:0], char_i};
          len_d = sat_inc(len_q);
          consumed = 1'b1;
        end else begin
          recs[n[0]] = mk_rec(ident_kind(kwbuf_q, len_q), start_q, len_q, ST_TOKEN);
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(char_i) || char_i == CH_UNDER) begin
          len_d = sat_inc(len_q);
          consumed = 1'b1;
        end else begin
          recs[n[0]] = mk_rec(KIND_NUMBER, start_q, len_q, ST_TOKEN);
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        consumed = 1'b1;
        if (char_i == quote_q) begin
          len_d = sat_inc(len_q);
          recs[n[0]] = mk_rec(KIND_STRING, start_q, len_d, ST_TOKEN);
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end else if (char_i == CH_NUL) begin
          recs[n[0]] = mk_rec(KIND_NONE, start_q, len_q, ST_UNTERM);
          n = n + 2'd1;
          mode_d = MODE_HALT;
        end else begin
          len_d = sat_inc(len_q);
        end
      end
      MODE_HALT: consumed = 1'b1;
      default:   mode_d = MODE_IDLE;
    endcase

    // new token
    if (!consumed && !is_space(char_i)) begin
      if (sk.hit) begin
        mode_d  = MODE_OP;
        pend_d  = char_i;
        start_d = pos16;
        len_d   = 16'd1;
      end else if (ik.hit) begin
        recs[n[0]] = mk_rec(ik.kind, pos16, 16'd1, ST_TOKEN);
        n = n + 2'd1;
      end else begin
        start_d = pos16;
        len_d   = 16'd1;
        if (is_alpha(char_i) || char_i == CH_UNDER) begin
          mode_d  = MODE_IDENT;
          kwbuf_d = KW_W'(char_i);
        end else if (char_i == CH_SQUOT || char_i == CH_DQUOT) begin
          mode_d  = MODE_STRING;
          quote_d = char_i;
        end else if (is_digit(char_i)) begin
          mode_d = MODE_NUMBER;
        end else begin
          recs[n[0]] = mk_rec(KIND_NONE, pos16, 16'd1, ST_BAD_CHAR);
          n = n + 2'd1;
          mode_d = MODE_HALT;
        end
      end
    end

    // end of source: flush whatever is open and restart
    flush_op = single_kind(pend_d);
    if (eos_i) begin
      case (mode_d)
        MODE_OP: begin
          recs[n[0]] = mk_rec(flush_op.kind, start_d, 16'd1, ST_TOKEN);
          n = n + 2'd1;
        end
        MODE_IDENT: begin
          recs[n[0]] = mk_rec(ident_kind(kwbuf_d, len_d), start_d, len_d, ST_TOKEN);
          n = n + 2'd1;
        end
        MODE_NUMBER: begin
          recs[n[0]] = mk_rec(KIND_NUMBER, start_d, len_d, ST_TOKEN);
          n = n + 2'd1;
        end
        MODE_STRING: begin
          recs[n[0]] = mk_rec(KIND_NONE, start_d, len_d, ST_UNTERM);
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_d = MODE_IDLE;
      pos_d  = '0;
    end else begin
      pos_d = pos_wrap ? '0 : pos_inc[POS_W-1:0];
    end

    // mark the last record of this item
    if (n == 2'd1) recs[0].last = 1'b1;
    if (n == 2'd2) recs[1].last = 1'b1;

    push_o.n    = fire_i ? n : 2'd0;
    push_o.rec0 = recs[0];
    push_o.rec1 = recs[1];
  end

  // State update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      pend_q  <= '0;
      quote_q <= '0;
      kwbuf_q <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      pend_q  <= pend_d;
      quote_q <= quote_d;
      kwbuf_q <= kwbuf_d;
      len_q   <= len_d;
    end
  end

endmodule

>>> src/stok_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stok_out_fifo
// Small record queue: takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
module stok_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stok_pkg::push_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            pop_i,
  output stok_pkg::rec_t  head_o
);
  import stok_pkg::*;

  rec_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_nx;

  assign valid_o   = count_q != '0;
  assign room_o    = count_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign pop       = valid_o & pop_i;
  assign head_o    = mem_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + FIFO_AW'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(push_i.n);
    rd_ptr_d = rd_ptr_q + FIFO_AW'(pop);
    count_d  = count_q + (FIFO_AW+1)'(push_i.n) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Record storage
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q]  <= push_i.rec0;
    if (push_i.n == 2'd2) mem_q[wr_ptr_nx] <= push_i.rec1;
  end

endmodule

>>> src/source_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_unit
// Streaming lexer: source bytes in, token records out.
// ----------------------------------------------------------------------------
// Takes one source byte per clock and decodes it in the same cycle against
// the lexer state, writing zero, one or two token records into a four-entry
// output queue; records leave at one per cycle while m_axis_tready is high.
// The input is ready whenever the queue has two free entries, so a byte is
// taken every cycle as long as the downstream side drains records about as
// fast as they are made; the queue's drain rate is what limits throughput.
// Records are registered in the queue. tlast on the input marks the last
// byte of a source: any open token is flushed and position restarts at zero.
module source_tokenizer_unit #(
  parameter longint unsigned MAX_SOURCE_LENGTH = stok_pkg::MAX_SOURCE_LENGTH_DEF,
  parameter int              KEYWORD_CHARS     = stok_pkg::KEYWORD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // source bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // end_of_source
  // token records
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [5:0] token_kind, [21:6] start_pos,
                                      // [37:22] token_len, [39:38] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // run_last
);
  import stok_pkg::*;

  logic  in_fire;
  logic  room;
  push_t push;
  rec_t  head;

  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid & room;

  // Per-byte decode and lexer state
  stok_lexer #(
    .MAX_SOURCE_LENGTH (MAX_SOURCE_LENGTH),
    .KEYWORD_CHARS     (KEYWORD_CHARS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .char_i (s_axis_tdata),
    .eos_i  (s_axis_tlast),
    .push_o (push)
  );

  // Output record queue
  stok_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {2'b00, head.len, head.start, head.kind};
  assign m_axis_tuser = head.status;
  assign m_axis_tlast = head.last;

  // The input only stalls while records are waiting downstream
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output queue");

  // A byte that yields records makes the output valid in the next cycle
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && push.n != 2'd0) |=> m_axis_tvalid)
    else $error("records pushed but output not valid");

  // With two records, only the second closes the item's run
  a_last_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (!push.rec0.last && push.rec1.last))
    else $error("run_last misplaced in a record pair");

endmodule
